// File: design/shg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturating histogram package
// Shared constants, operation codes and the control and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package shg_pkg;

    localparam int BIN_COUNT_DEF   = 4096;
    localparam int COUNT_WIDTH_DEF = 7;
    localparam int INDEX_W         = 12;
    localparam int CAP_W           = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd127;

    typedef enum logic {
        OP_COUNT = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef struct packed {
        logic clear_wr;
        logic take;
        logic update;
    } shg_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic accepted;
        logic out_free;
    } shg_sts_t;

endpackage

// File: design/shg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturating histogram channels
// Valid/ready channels for sample items, result items and the cap register.
// ----------------------------------------------------------------------------
interface shg_in_if;
    import shg_pkg::*;

    logic                 valid;
    logic                 ready;
    op_t                  operation;
    logic [INDEX_W-1:0]   bin_index;

    modport source (output valid, output operation, output bin_index, input ready);
    modport sink (input valid, input operation, input bin_index, output ready);
endinterface

interface shg_out_if;
    import shg_pkg::*;

    logic               valid;
    logic               ready;
    logic [CAP_W-1:0]   bin_count;
    logic               at_cap;

    modport source (output valid, output bin_count, output at_cap, input ready);
    modport sink (input valid, input bin_count, input at_cap, output ready);
endinterface

interface shg_cfg_if;
    import shg_pkg::*;

    logic               valid;
    logic               ready;
    logic [CAP_W-1:0]   bin_cap;

    modport source (output valid, output bin_cap, input ready);
    modport sink (input valid, input bin_cap, output ready);
endinterface

// File: design/shg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module shg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/shg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturating histogram controller
// Sequences the clearing pass, item acceptance and the bin update.
// ----------------------------------------------------------------------------
module shg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  shg_pkg::shg_sts_t sts,
    output shg_pkg::shg_cmd_t cmd
);
    import shg_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (sts.accepted)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.clear_wr = (state_reg == ST_CLEAR);
    assign cmd.take     = (state_reg == ST_IDLE);
    assign cmd.update   = (state_reg == ST_UPDATE);

    // An accepted item is always followed by its update cycle.
    a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
        sts.accepted |=> state_reg == ST_UPDATE)
        else $error("accepted item not followed by update");

    // No item is taken while the store is being cleared.
    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !sts.accepted)
        else $error("item accepted during clearing pass");

    // A committed update returns to idle.
    a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && sts.out_free |=> state_reg == ST_IDLE)
        else $error("update did not return to idle");

endmodule

// File: design/shg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturating histogram datapath
// Bin store, saturating increment, cap register and result register.
// ----------------------------------------------------------------------------
module shg_dp #(
    parameter int BIN_COUNT   = shg_pkg::BIN_COUNT_DEF,
    parameter int COUNT_WIDTH = shg_pkg::COUNT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    shg_in_if.sink            samples,
    shg_out_if.source         results,
    shg_cfg_if.sink           cfg,
    input  shg_pkg::shg_cmd_t cmd,
    output shg_pkg::shg_sts_t sts
);
    import shg_pkg::*;

    localparam int ADDR_W = $clog2(BIN_COUNT);

    logic [ADDR_W-1:0]      clr_addr_reg;
    logic [ADDR_W-1:0]      clr_addr_next;
    logic [CAP_W-1:0]       cap_reg;
    op_t                    op_reg;
    logic                   in_range_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CAP_W-1:0]       bin_count_reg;
    logic                   at_cap_reg;

    logic [31:0]            idx_ext;
    logic [ADDR_W-1:0]      idx_addr;
    logic                   idx_in_range;
    logic                   accepted;
    logic                   commit;
    logic                   clear_last;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [COUNT_WIDTH-1:0] new_cnt;
    logic [31:0]            cnt_ext;
    logic [31:0]            new_ext;
    logic [31:0]            cap_ext;
    logic                   inc;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;

    assign idx_ext      = 32'(samples.bin_index);
    assign idx_addr     = idx_ext[ADDR_W-1:0];
    assign idx_in_range = idx_ext < 32'(BIN_COUNT);

    assign samples.ready = cmd.take;
    assign accepted      = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;

    assign clear_last    = (clr_addr_reg == ADDR_W'(BIN_COUNT - 1));
    assign clr_addr_next = clear_last ? '0 : clr_addr_reg + ADDR_W'(1);

    assign cnt_ext = 32'(cnt);
    assign cap_ext = 32'(cap_reg);
    assign inc     = (op_reg == OP_COUNT) && (cnt_ext < cap_ext) && !(&cnt);
    assign new_cnt = inc ? cnt + COUNT_WIDTH'(1) : cnt;
    assign new_ext = 32'(new_cnt);

    assign sts.out_free   = !out_valid_reg || results.ready;
    assign sts.accepted   = accepted;
    assign sts.clear_last = clear_last;
    assign commit         = cmd.update && sts.out_free;

    assign wr_en   = cmd.clear_wr || (commit && in_range_reg && inc);
    assign wr_addr = cmd.clear_wr ? clr_addr_reg : addr_reg;
    assign wr_data = cmd.clear_wr ? '0 : new_cnt;

    shg_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (BIN_COUNT)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accepted),
        .rd_addr (idx_addr),
        .rd_data (cnt)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_next;
            end
            if (cfg.valid && cfg.ready)
            begin
                cap_reg <= cfg.bin_cap;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accepted)
        begin
            op_reg       <= samples.operation;
            in_range_reg <= idx_in_range;
            addr_reg     <= idx_addr;
        end
        if (commit)
        begin
            bin_count_reg <= in_range_reg ? new_ext[CAP_W-1:0] : '0;
            at_cap_reg    <= in_range_reg && (new_ext >= cap_ext);
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.bin_count = bin_count_reg;
    assign results.at_cap    = at_cap_reg;

    // A result appears only from a committed update.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(commit))
        else $error("result raised without an update");

    // The store is never written by an item during the clearing pass.
    a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> !commit)
        else $error("item update during clearing pass");

endmodule

// File: design/saturating_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturating histogram
// A store of bins that count samples up to a programmable cap.
// ----------------------------------------------------------------------------
// The samples channel carries one item per sample: an operation (count or
// read) and a bin index. Each item yields exactly one item on the results
// channel with the bin's count after the item and a flag that is set when
// that count is at or above the cap. Indices beyond the last bin leave the
// store untouched and return a count of zero with the flag clear.
// The cfg channel writes the cap; it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// An item is handled in steps: first its bin is read from the store, whose read
// data is registered, and then it is updated and the result register loaded,
// so the block accepts no new item until the update of the last one commits.
// The result is valid once the result register has been loaded.
// After reset the store is cleared one bin a cycle through all BIN_COUNT
// bins (4096 by default); no item is accepted until this pass ends.
// The cap returns to 127 at reset.
// When the receiver stalls, the finished result waits in the output register
// and one further item may be accepted and read; its update then waits until
// the register is free.
// ----------------------------------------------------------------------------
module saturating_histogram #(
    parameter int BIN_COUNT   = shg_pkg::BIN_COUNT_DEF,
    parameter int COUNT_WIDTH = shg_pkg::COUNT_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    shg_in_if.sink    samples,
    shg_out_if.source results,
    shg_cfg_if.sink   cfg
);
    import shg_pkg::*;

    shg_cmd_t cmd;
    shg_sts_t sts;

    shg_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    shg_dp #(
        .BIN_COUNT   (BIN_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results),
        .cfg     (cfg),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
